[src/assert_macros.svh]
// Assertion macros shared by the normal-matrix RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NMIT_AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("nmit assertion failed");

// Next-cycle implication, disabled while reset is low.
`define NMIT_AST_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("nmit assertion failed");

`endif

[src/nmit_pkg.sv]
// Package for the normal-matrix inverse-transpose block: widths and constants.
// Depends on nothing; used by the channel interfaces and the core.
package nmit_pkg;

  localparam int ELEM_W        = 32;  // Q-format element width
  localparam int COF_W         = 65;  // exact signed cofactor width
  localparam int DET_W         = 99;  // exact signed determinant width
  localparam int LIMIT_W       = 31;  // singular limit register width
  localparam int QBITS         = 33;  // quotient bits resolved by the divider
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(66);

endpackage

[src/nmit_ifs.sv]
// Valid/ready channel interfaces for the normal-matrix block.
// Depends on nmit_pkg.

interface nmit_in_if;
  import nmit_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] in_r0c0, in_r0c1, in_r0c2;
  logic signed [ELEM_W-1:0] in_r1c0, in_r1c1, in_r1c2;
  logic signed [ELEM_W-1:0] in_r2c0, in_r2c1, in_r2c2;
  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface nmit_out_if;
  import nmit_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] out_r0c0, out_r0c1, out_r0c2;
  logic signed [ELEM_W-1:0] out_r1c0, out_r1c1, out_r1c2;
  logic signed [ELEM_W-1:0] out_r2c0, out_r2c1, out_r2c2;
  logic                     singular;
  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, input ready);
  modport sink (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                out_r2c0, out_r2c1, out_r2c2, singular, output ready);
endinterface

interface nmit_cfg_if;
  import nmit_pkg::*;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] singular_limit;
  modport source (output valid, singular_limit, input ready);
  modport sink (input valid, singular_limit, output ready);
endinterface

[src/normal_matrix_inverse_transpose_core.sv]
// Throughput one matrix per cycle while the result beat is not held by the receiver.
// The depth is set by the 33-stage restoring divider (one quotient bit per stage,
// nine lanes side by side) behind an 8-stage cofactor/determinant front end.
// The whole pipe advances together; it stalls only while a result beat is refused.
// Reset (rst_n low, synchronous) empties the pipe and sets singular_limit to 66.
// Depends on nmit_pkg, nmit_ifs and assert_macros.svh.
`include "assert_macros.svh"

module normal_matrix_inverse_transpose_core #(
  parameter int FRAC_BITS = nmit_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nmit_in_if.sink    in_bus,
  nmit_out_if.source out_bus,
  nmit_cfg_if.sink   cfg_bus
);
  import nmit_pkg::*;

  localparam int CMAG_W = COF_W - 1;
  localparam int DMAG_W = DET_W - 1;
  localparam int DV_W   = DMAG_W + 1;
  localparam int NUM_W  = CMAG_W + 2 * FRAC_BITS + 2;
  localparam int DVS_W  = DV_W + QBITS;
  localparam int W      = (NUM_W > DVS_W) ? NUM_W : DVS_W;
  localparam int FRONT  = 8;
  localparam int NSTG   = FRONT + QBITS + 1;
  localparam logic [ELEM_W-1:0] ONE_Q   = ELEM_W'(1) << FRAC_BITS;
  localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

  logic [NSTG-1:0]    v_r;
  logic               adv;
  logic [LIMIT_W-1:0] lim_r;

  logic signed [ELEM_W-1:0]   m [3][3];
  logic signed [2*ELEM_W-1:0] prod [18];

  logic signed [2*ELEM_W-1:0] s0_prod_r [18];
  logic signed [ELEM_W-1:0]   s0_row_r [3];
  logic signed [COF_W-1:0]    s1_cof_r [9];
  logic signed [ELEM_W-1:0]   s1_row_r [3];
  logic signed [COF_W-1:0]    s2_plo_r [3];
  logic signed [COF_W-1:0]    s2_phi_r [3];
  logic signed [COF_W-1:0]    s2_cof_r [9];
  logic signed [DET_W-1:0]    s3_term_r [3];
  logic signed [COF_W-1:0]    s3_cof_r [9];
  logic signed [DET_W-1:0]    s4_det_r;
  logic signed [COF_W-1:0]    s4_cof_r [9];
  logic [DMAG_W-1:0]          s5_dmag_r;
  logic [CMAG_W-1:0]          s5_cmag_r [9];
  logic                       s5_neg_r [9];
  logic [W-1:0]               s6_num_r [9];
  logic [DV_W-1:0]            s6_dv_r;
  logic                       s6_neg_r [9];
  logic                       s6_sing_r;
  logic [W-1:0]               s7_num_r [9];
  logic [DV_W-1:0]            s7_dv_r;
  logic                       s7_neg_r [9];
  logic                       s7_ovf_r [9];
  logic                       s7_sing_r;

  logic [W-1:0]       dv_rem_r [QBITS-1][9];
  logic [QBITS-1:0]   dv_q_r [QBITS][9];
  logic               dv_neg_r [QBITS][9];
  logic               dv_ovf_r [QBITS][9];
  logic [DV_W-1:0]    dv_d_r [QBITS-1];
  logic               dv_sing_r [QBITS];

  logic [ELEM_W-1:0]  out_el_r [9];
  logic               out_sing_r;

  // Global pipe advance: move unless the result beat is held
  assign adv          = !v_r[NSTG-1] || out_bus.ready;
  assign in_bus.ready = adv && rst_n;
  assign cfg_bus.ready = rst_n;

  // Element view of the input beat
  assign m[0][0] = in_bus.in_r0c0;
  assign m[0][1] = in_bus.in_r0c1;
  assign m[0][2] = in_bus.in_r0c2;
  assign m[1][0] = in_bus.in_r1c0;
  assign m[1][1] = in_bus.in_r1c1;
  assign m[1][2] = in_bus.in_r1c2;
  assign m[2][0] = in_bus.in_r2c0;
  assign m[2][1] = in_bus.in_r2c1;
  assign m[2][2] = in_bus.in_r2c2;

  // Cofactor products, two per cofactor (first minus second)
  always_comb begin
    prod[0]  = m[1][1] * m[2][2];  prod[1]  = m[1][2] * m[2][1];
    prod[2]  = m[1][2] * m[2][0];  prod[3]  = m[1][0] * m[2][2];
    prod[4]  = m[1][0] * m[2][1];  prod[5]  = m[1][1] * m[2][0];
    prod[6]  = m[0][2] * m[2][1];  prod[7]  = m[0][1] * m[2][2];
    prod[8]  = m[0][0] * m[2][2];  prod[9]  = m[0][2] * m[2][0];
    prod[10] = m[0][1] * m[2][0];  prod[11] = m[0][0] * m[2][1];
    prod[12] = m[0][1] * m[1][2];  prod[13] = m[0][2] * m[1][1];
    prod[14] = m[0][2] * m[1][0];  prod[15] = m[0][0] * m[1][2];
    prod[16] = m[0][0] * m[1][1];  prod[17] = m[0][1] * m[1][0];
  end

  // Control: valid shift and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      lim_r <= LIMIT_RST;
    end else begin
      if (adv) begin
        v_r <= {v_r[NSTG-2:0], in_bus.valid};
      end
      if (cfg_bus.valid) begin
        lim_r <= cfg_bus.singular_limit;
      end
    end
  end

  // Front end: cofactors, determinant, magnitudes, singular test, overflow test
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 18; i++) s0_prod_r[i] <= prod[i];
      for (int i = 0; i < 3; i++) s0_row_r[i] <= m[0][i];

      for (int i = 0; i < 9; i++) begin
        s1_cof_r[i] <= COF_W'(s0_prod_r[2*i]) - COF_W'(s0_prod_r[2*i+1]);
      end
      s1_row_r <= s0_row_r;

      // determinant terms split into low and high cofactor halves
      for (int i = 0; i < 3; i++) begin
        s2_plo_r[i] <= s1_row_r[i] * $signed({1'b0, s1_cof_r[i][ELEM_W-1:0]});
        s2_phi_r[i] <= s1_row_r[i] * $signed(s1_cof_r[i][COF_W-1:ELEM_W]);
      end
      s2_cof_r <= s1_cof_r;

      for (int i = 0; i < 3; i++) begin
        s3_term_r[i] <= (DET_W'(s2_phi_r[i]) <<< ELEM_W) + DET_W'(s2_plo_r[i]);
      end
      s3_cof_r <= s2_cof_r;

      s4_det_r <= s3_term_r[0] + s3_term_r[1] + s3_term_r[2];
      s4_cof_r <= s3_cof_r;

      // sign and magnitude
      s5_dmag_r <= DMAG_W'(s4_det_r[DET_W-1] ? -s4_det_r : s4_det_r);
      for (int i = 0; i < 9; i++) begin
        s5_cmag_r[i] <= CMAG_W'(s4_cof_r[i][COF_W-1] ? -s4_cof_r[i] : s4_cof_r[i]);
        s5_neg_r[i]  <= s4_cof_r[i][COF_W-1] ^ s4_det_r[DET_W-1];
      end

      // rounding numerator |C|*2^(2F+1)+|D| over divisor 2|D|
      s6_sing_r <= (s5_dmag_r == '0) ||
                   (s5_dmag_r < (DMAG_W'(lim_r) << (2 * FRAC_BITS)));
      s6_dv_r   <= {s5_dmag_r, 1'b0};
      for (int i = 0; i < 9; i++) begin
        s6_num_r[i] <= (W'(s5_cmag_r[i]) << (2 * FRAC_BITS + 1)) + W'(s5_dmag_r);
      end
      s6_neg_r <= s5_neg_r;

      // quotient beyond the divider's bit range saturates
      for (int i = 0; i < 9; i++) begin
        s7_ovf_r[i] <= s6_num_r[i] >= (W'(s6_dv_r) << QBITS);
      end
      s7_num_r  <= s6_num_r;
      s7_dv_r   <= s6_dv_r;
      s7_neg_r  <= s6_neg_r;
      s7_sing_r <= s6_sing_r;
    end
  end

  // Restoring divider: stage j resolves quotient bit QBITS-1-j
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    localparam int K = QBITS - 1 - j;
    logic [W-1:0]     rem_in [9];
    logic [QBITS-1:0] q_in [9];
    logic             neg_in [9];
    logic             ovf_in [9];
    logic [DV_W-1:0]  d_in;
    logic             sing_in;
    logic [W-1:0]     sub;

    if (j == 0) begin : g_first
      always_comb begin
        rem_in  = s7_num_r;
        q_in    = '{default: '0};
        neg_in  = s7_neg_r;
        ovf_in  = s7_ovf_r;
        d_in    = s7_dv_r;
        sing_in = s7_sing_r;
      end
    end else begin : g_next
      always_comb begin
        rem_in  = dv_rem_r[j-1];
        q_in    = dv_q_r[j-1];
        neg_in  = dv_neg_r[j-1];
        ovf_in  = dv_ovf_r[j-1];
        d_in    = dv_d_r[j-1];
        sing_in = dv_sing_r[j-1];
      end
    end

    assign sub = W'(d_in) << K;

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 9; i++) begin
          dv_q_r[j][i] <= {q_in[i][QBITS-2:0], rem_in[i] >= sub};
        end
        dv_neg_r[j]  <= neg_in;
        dv_ovf_r[j]  <= ovf_in;
        dv_sing_r[j] <= sing_in;
      end
    end

    // Partial remainder and divisor go on only while bits remain
    if (j < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int i = 0; i < 9; i++) begin
            dv_rem_r[j][i] <= (rem_in[i] >= sub) ? rem_in[i] - sub : rem_in[i];
          end
          dv_d_r[j] <= d_in;
        end
      end
    end
  end

  // Output stage: sign, saturation, identity on singular
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        if (dv_sing_r[QBITS-1]) begin
          out_el_r[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q : '0;
        end else if (dv_neg_r[QBITS-1][i]) begin
          if (dv_ovf_r[QBITS-1][i] || dv_q_r[QBITS-1][i] > QBITS'(MIN_NEG)) begin
            out_el_r[i] <= MIN_NEG;
          end else begin
            out_el_r[i] <= ELEM_W'(QBITS'(0) - dv_q_r[QBITS-1][i]);
          end
        end else begin
          if (dv_ovf_r[QBITS-1][i] || dv_q_r[QBITS-1][i] > QBITS'(MAX_POS)) begin
            out_el_r[i] <= MAX_POS;
          end else begin
            out_el_r[i] <= ELEM_W'(dv_q_r[QBITS-1][i]);
          end
        end
      end
      out_sing_r <= dv_sing_r[QBITS-1];
    end
  end

  assign out_bus.valid    = v_r[NSTG-1];
  assign out_bus.out_r0c0 = out_el_r[0];
  assign out_bus.out_r0c1 = out_el_r[1];
  assign out_bus.out_r0c2 = out_el_r[2];
  assign out_bus.out_r1c0 = out_el_r[3];
  assign out_bus.out_r1c1 = out_el_r[4];
  assign out_bus.out_r1c2 = out_el_r[5];
  assign out_bus.out_r2c0 = out_el_r[6];
  assign out_bus.out_r2c1 = out_el_r[7];
  assign out_bus.out_r2c2 = out_el_r[8];
  assign out_bus.singular = out_sing_r;

  // Checks
  `NMIT_AST_IMP(a_sing_ident, clk, rst_n, out_bus.valid && out_bus.singular, out_bus.out_r0c0 == ONE_Q && out_bus.out_r0c1 == '0 && out_bus.out_r2c2 == ONE_Q)
  `NMIT_AST_NXT(a_accept_v0, clk, rst_n, in_bus.valid && in_bus.ready, v_r[0])
  `NMIT_AST_NXT(a_stall_hold, clk, rst_n, !adv, v_r == $past(v_r))

endmodule

[sim/tb.sv]
// Testbench for normal_matrix_inverse_transpose_core: 3x3 inverse-transpose in Q16.16.
// Drives directed and random matrices and checks every result beat against a predictor or typed expectation.
// Depends on nmit_pkg and the channel interfaces in nmit_ifs.sv.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nmit_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int DRAIN_CYC = 60;
  localparam int MAX_CYC   = 600000;
  localparam int N_RANDOM  = 1100;

  typedef struct {
    logic signed [ELEM_W-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [ELEM_W-1:0] e [9];
    logic                     sing;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nmit_in_if  in_if ();
  nmit_out_if out_if ();
  nmit_cfg_if cfg_if ();

  normal_matrix_inverse_transpose_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #2 clk = ~clk;

  normal_t         normal_q [$];
  logic [LIMIT_W-1:0] limit_shadow = LIMIT_RST;
  int              mismatches = 0;
  int              cycles = 0;
  int              hold_req = 0;

  // Exact inverse-transpose with one rounding, identity when the determinant is too small.
  function automatic normal_t predict_normal(matrix_t a, logic [LIMIT_W-1:0] lim);
    logic signed [127:0] m [9];
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    logic [127:0]        adet, thr, ac, num, q;
    logic                neg;
    normal_t             r;
    for (int i = 0; i < 9; i++) m[i] = a.m[i];
    c[0] = m[4]*m[8] - m[5]*m[7];
    c[1] = m[5]*m[6] - m[3]*m[8];
    c[2] = m[3]*m[7] - m[4]*m[6];
    c[3] = m[2]*m[7] - m[1]*m[8];
    c[4] = m[0]*m[8] - m[2]*m[6];
    c[5] = m[1]*m[6] - m[0]*m[7];
    c[6] = m[1]*m[5] - m[2]*m[4];
    c[7] = m[2]*m[3] - m[0]*m[5];
    c[8] = m[0]*m[4] - m[1]*m[3];
    det  = m[0]*c[0] + m[1]*c[1] + m[2]*c[2];
    adet = det < 0 ? -det : det;
    thr  = 128'(lim) << (2*FB);
    if (det == 0 || adet < thr) begin
      for (int i = 0; i < 9; i++) r.e[i] = (i % 4 == 0) ? ELEM_W'(1) << FB : '0;
      r.sing = 1'b1;
      return r;
    end
    for (int i = 0; i < 9; i++) begin
      ac  = c[i] < 0 ? -c[i] : c[i];
      neg = (c[i] < 0) != (det < 0);
      num = (ac << (2*FB + 1)) + adet;
      q   = num / (adet << 1);
      if (neg) r.e[i] = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
      else     r.e[i] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    r.sing = 1'b0;
    return r;
  endfunction

  // Result beat checker
  always @(posedge clk) begin
    normal_t got, want;
    bit      bad;
    cycles <= cycles + 1;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.e = '{out_if.out_r0c0, out_if.out_r0c1, out_if.out_r0c2,
                out_if.out_r1c0, out_if.out_r1c1, out_if.out_r1c2,
                out_if.out_r2c0, out_if.out_r2c1, out_if.out_r2c2};
      got.sing = out_if.singular;
      if (normal_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, singular=%0b", got.sing);
      end else begin
        want = normal_q.pop_front();
        bad = (got.sing !== want.sing);
        for (int i = 0; i < 9; i++) if (got.e[i] !== want.e[i]) bad = 1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: singular exp %0b got %0b", want.sing, got.sing);
            for (int i = 0; i < 9; i++)
              $display("  r%0dc%0d exp %h got %h", i / 3, i % 3, want.e[i], got.e[i]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycles > MAX_CYC) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver: rotating stall patterns plus requested long hold-offs
  always @(negedge clk) begin
    int hold_left;
    int mode;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    mode = (cycles / 97) % 4;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 1) == 1);
        2:       out_if.ready <= (cycles % 5 != 0);
        default: out_if.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Drive one matrix beat; the expectation is queued at acceptance.
  task automatic send_matrix(matrix_t a, bit typed, normal_t typed_exp);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.in_r0c0 <= a.m[0]; in_if.in_r0c1 <= a.m[1]; in_if.in_r0c2 <= a.m[2];
    in_if.in_r1c0 <= a.m[3]; in_if.in_r1c1 <= a.m[4]; in_if.in_r1c2 <= a.m[5];
    in_if.in_r2c0 <= a.m[6]; in_if.in_r2c1 <= a.m[7]; in_if.in_r2c2 <= a.m[8];
    do @(posedge clk); while (!in_if.ready);
    normal_q.push_back(typed ? typed_exp : predict_normal(a, limit_shadow));
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_all();
    idle_input(0);
    wait (normal_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    drain_all();
    cfg_if.valid <= 1'b1;
    cfg_if.singular_limit <= v;
    do @(posedge clk); while (!cfg_if.ready);
    limit_shadow = v;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] rnd_small(int mag);
    return $signed(ELEM_W'($urandom_range(0, 2*mag))) - mag;
  endfunction

  // Random matrix with a mix of shapes: full-range noise, well-conditioned, exactly singular
  function automatic matrix_t rnd_matrix();
    matrix_t a;
    int      kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0, 1:    a.m[i] = $urandom;
        2, 3, 4: a.m[i] = (i % 4 == 0) ? rnd_small(1 << 19) : rnd_small(1 << 17);
        5:       a.m[i] = rnd_small(1 << 24);
        6:       a.m[i] = rnd_small(1 << 10);
        7:       a.m[i] = (i % 4 == 0) ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                       : rnd_small(1 << 20);
        default: a.m[i] = rnd_small(1 << 18);
      endcase
    end
    // Singular: copy a row so the determinant is exactly zero
    if (kind == 9) for (int j = 0; j < 3; j++) a.m[6 + j] = a.m[j];
    return a;
  endfunction

  // Directed table; typed expectations where the answer is obvious
  typedef struct {
    matrix_t a;
    bit      typed;
    normal_t r;
  } row_t;

  localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(1) << FB;
  localparam logic signed [ELEM_W-1:0] MAXV = 32'h7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] MINV = 32'h8000_0000;

  task automatic run_rows(row_t rows [$]);
    foreach (rows[i]) send_matrix(rows[i].a, rows[i].typed, rows[i].r);
  endtask

  function automatic row_t mk(logic signed [ELEM_W-1:0] d, logic signed [ELEM_W-1:0] o,
                              bit typed, logic signed [ELEM_W-1:0] rd,
                              logic signed [ELEM_W-1:0] ro, logic sing);
    row_t x;
    for (int i = 0; i < 9; i++) begin
      x.a.m[i] = (i % 4 == 0) ? d : o;
      x.r.e[i] = (i % 4 == 0) ? rd : ro;
    end
    x.typed  = typed;
    x.r.sing = sing;
    return x;
  endfunction

  initial begin
    row_t    rows [$];
    row_t    tmp;
    int      burst;
    int      sent;
    in_if.valid = 1'b0;
    in_if.in_r0c0 = '0; in_if.in_r0c1 = '0; in_if.in_r0c2 = '0;
    in_if.in_r1c0 = '0; in_if.in_r1c1 = '0; in_if.in_r1c2 = '0;
    in_if.in_r2c0 = '0; in_if.in_r2c1 = '0; in_if.in_r2c2 = '0;
    cfg_if.valid = 1'b0;
    cfg_if.singular_limit = '0;
    out_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Default limit: zero, identity, scaled identity, extremes, tiny determinant
    rows.push_back(mk('0, '0, 1, ONE, '0, 1'b1));
    rows.push_back(mk(ONE, '0, 1, ONE, '0, 1'b0));
    rows.push_back(mk(ONE << 1, '0, 1, ONE >> 1, '0, 1'b0));
    rows.push_back(mk(-ONE, '0, 1, -ONE, '0, 1'b0));
    rows.push_back(mk(MAXV, MAXV, 1, ONE, '0, 1'b1));
    rows.push_back(mk(MINV, MINV, 1, ONE, '0, 1'b1));
    rows.push_back(mk(32'sd1, '0, 1, ONE, '0, 1'b1));
    rows.push_back(mk(32'sh100, '0, 1, ONE, '0, 1'b1));
    rows.push_back(mk(MINV, '0, 0, '0, '0, 1'b0));
    rows.push_back(mk(MAXV, '0, 0, '0, '0, 1'b0));
    rows.push_back(mk(MAXV, MINV, 0, '0, '0, 1'b0));
    rows.push_back(mk(ONE, -ONE >> 1, 0, '0, '0, 1'b0));
    tmp = mk(ONE, '0, 0, '0, '0, 1'b0);
    tmp.a.m[1] = 32'h0001_8000; tmp.a.m[5] = -32'sh0002_0000; tmp.a.m[6] = 32'h0000_4000;
    rows.push_back(tmp);
    run_rows(rows);

    // Zero limit: only an exactly zero determinant is singular; tiny det saturates
    write_limit('0);
    rows.delete();
    rows.push_back(mk('0, '0, 1, ONE, '0, 1'b1));
    rows.push_back(mk(32'sd1, '0, 1, MAXV, '0, 1'b0));
    rows.push_back(mk(-32'sd1, '0, 1, MINV, '0, 1'b0));
    rows.push_back(mk(32'sh100, 32'sh1, 0, '0, '0, 1'b0));
    run_rows(rows);

    // Largest limit
    write_limit({LIMIT_W{1'b1}});
    rows.delete();
    rows.push_back(mk(ONE, '0, 1, ONE, '0, 1'b1));
    rows.push_back(mk(MINV, '0, 0, '0, '0, 1'b0));
    rows.push_back(mk(MAXV, 32'sh1234_5678, 0, '0, '0, 1'b0));
    run_rows(rows);

    // Random phases, each with its own limit
    sent = 0;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_limit(LIMIT_RST);
        1:       write_limit(LIMIT_W'($urandom));
        2:       write_limit('0);
        3:       write_limit(LIMIT_W'($urandom_range(0, 1 << 20)));
        default: write_limit(LIMIT_RST);
      endcase
      // Long receiver hold-off while the sender keeps pushing
      if (ph == 1) hold_req = 300;
      while (sent < (ph + 1) * N_RANDOM / 5) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++) send_matrix(rnd_matrix(), 1'b0, predict_normal('{m: '{default: '0}}, '0));
        sent += burst;
        if (ph != 0 && $urandom_range(0, 3) != 0) idle_input($urandom_range(0, 6));
      end
      // Sender waits for everything to come back
      if (ph == 2) drain_all();
    end

    drain_all();
    if (mismatches == 0 && normal_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
